// ----- rtl/prts_pkg.sv -----
`default_nettype none

package prts_pkg;

    localparam int FUNC_W   = 2;
    localparam int MODE_W   = 2;
    localparam int ID_W     = 31;
    localparam int PRI_W    = 7;
    localparam int BURST_W  = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int LEFT_W   = 6;
    localparam int LFSR_W   = 16;
    localparam int KEY_W    = 16;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [PRI_W-1:0]    pri_t;
    typedef logic [BURST_W-1:0]  burst_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [LEFT_W-1:0]   left_t;
    typedef logic [LFSR_W-1:0]   lfsr_t;
    typedef logic [KEY_W-1:0]    key_t;

    localparam func_t FUNC_LOAD     = 2'd0;
    localparam func_t FUNC_DISPATCH = 2'd1;
    localparam func_t FUNC_TICK     = 2'd2;

    localparam mode_t MODE_FCFS     = 2'd0;
    localparam mode_t MODE_RANDOM   = 2'd1;
    localparam mode_t MODE_SHORTEST = 2'd2;
    localparam mode_t MODE_PRIORITY = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam lfsr_t LFSR_SEED = 16'h0001;
    localparam lfsr_t LFSR_MASK = 16'hB400;

    // Galois LFSR, shift right
    function automatic lfsr_t lfsr_step(input lfsr_t v);
        lfsr_t s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/prts_ram.sv -----
`default_nettype none

module prts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/prts_divmod.sv -----
`default_nettype none

// restoring remainder, one dividend bit per cycle
module prts_divmod #(
    parameter int DW = 16,
    parameter int VW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic      [VW-1:0] rem
);

    localparam int SW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SW'(DW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/process_ready_table_scheduler_unit.sv -----
`default_nettype none

// Channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// cfg      | cfg_we                    | cfg_data (sched_mode)
// in       | in_valid / in_stall       | func, proc_id, proc_priority, burst_time
// out      | out_valid / out_stall     | status, slot, out_id, out_priority,
//          |                           | out_burst, left_count
//
// Load, rejected item, unused func: go straight to S_FINISH, then into the output register.
// Tick and dispatch scan in S_SCAN, one table slot per cycle through a single comparator
// and the RAM read port; dispatch then passes S_FETCH and S_LATCH before S_FINISH.
// Random dispatch first waits in S_DIV for the bit-serial LFSR modulo.
// Next item is taken in the cycle after the result is loaded into the output register.
// Reset clears counts and dispatched marks, seeds the LFSR and sets FCFS mode; no clearing pass.
// in_stall is high while an item is in progress; a stalled result is held.
module process_ready_table_scheduler_unit
    import prts_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire mode_t   cfg_data,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire func_t   func,
    input  wire id_t     proc_id,
    input  wire pri_t    proc_priority,
    input  wire burst_t  burst_time,
    output logic         out_valid,
    input  wire logic    out_stall,
    output status_t      status,
    output slot_t        slot,
    output id_t          out_id,
    output pri_t         out_priority,
    output burst_t       out_burst,
    output left_t        left_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_LATCH  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]             state_reg, state_next;
    mode_t                  mode_reg;
    logic [CW-1:0]          entry_reg, entry_next;
    logic [CW-1:0]          remain_reg, remain_next;
    lfsr_t                  lfsr_reg, lfsr_next;
    logic [TABLE_DEPTH-1:0] mark_reg, mark_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0]          pipe_idx_reg, pipe_idx_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          best_reg, best_next;
    key_t                   best_key_reg, best_key_next;
    logic [CW-1:0]          seen_reg, seen_next;
    logic [CW-1:0]          target_reg, target_next;
    logic                   tick_reg, tick_next;
    status_t                res_status_reg, res_status_next;
    slot_t                  res_slot_reg, res_slot_next;
    id_t                    res_id_reg, res_id_next;
    pri_t                   res_pri_reg, res_pri_next;
    burst_t                 res_burst_reg, res_burst_next;

    logic                   out_valid_reg;
    status_t                out_status_reg;
    slot_t                  out_slot_reg;
    id_t                    out_id_reg;
    pri_t                   out_pri_reg;
    burst_t                 out_burst_reg;
    left_t                  out_left_reg;
    logic                   out_load;

    logic                   load_we;
    logic                   pri_we;
    logic [AW-1:0]          pri_waddr;
    pri_t                   pri_wdata;
    logic [AW-1:0]          rd_addr;
    id_t                    id_rdata;
    pri_t                   pri_rdata;
    burst_t                 burst_rdata;

    logic                   div_start;
    lfsr_t                  lfsr_adv;
    logic                   div_done;
    logic [CW-1:0]          div_rem;

    logic                   issue;
    key_t                   key;
    key_t                   cmp_a, cmp_b;
    logic                   cmp_lt, cmp_eq;
    logic [SLOT_W+AW-1:0]   entry_wide, best_wide;
    logic [LEFT_W+CW-1:0]   left_wide;

    prts_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_reg[AW-1:0]),
        .wdata (proc_id),
        .raddr (rd_addr),
        .rdata (id_rdata)
    );

    prts_ram #(.WIDTH(PRI_W), .DEPTH(TABLE_DEPTH)) u_pri_ram (
        .clk   (clk),
        .we    (pri_we),
        .waddr (pri_waddr),
        .wdata (pri_wdata),
        .raddr (rd_addr),
        .rdata (pri_rdata)
    );

    prts_ram #(.WIDTH(BURST_W), .DEPTH(TABLE_DEPTH)) u_burst_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_reg[AW-1:0]),
        .wdata (burst_time),
        .raddr (rd_addr),
        .rdata (burst_rdata)
    );

    prts_divmod #(.DW(LFSR_W), .VW(CW)) u_divmod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lfsr_adv),
        .divisor  (remain_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign lfsr_adv   = lfsr_step(lfsr_reg);
    assign entry_wide = {{SLOT_W{1'b0}}, entry_reg[AW-1:0]};
    assign best_wide  = {{SLOT_W{1'b0}}, best_reg};
    assign left_wide  = {{LEFT_W{1'b0}}, remain_reg};

    // shared comparator: rank compare, or running count against random target
    always_comb
    begin
        key = (mode_reg == MODE_PRIORITY) ? KEY_W'(pri_rdata) : burst_rdata;
        if (mode_reg == MODE_RANDOM)
        begin
            cmp_a = KEY_W'(seen_reg);
            cmp_b = KEY_W'(target_reg);
        end
        else
        begin
            cmp_a = key;
            cmp_b = best_key_reg;
        end
        cmp_lt = cmp_a < cmp_b;
        cmp_eq = cmp_a == cmp_b;
    end

    always_comb
    begin
        state_next      = state_reg;
        entry_next      = entry_reg;
        remain_next     = remain_reg;
        lfsr_next       = lfsr_reg;
        mark_next       = mark_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = scan_idx_reg[AW-1:0];
        found_next      = found_reg;
        best_next       = best_reg;
        best_key_next   = best_key_reg;
        seen_next       = seen_reg;
        target_next     = target_reg;
        tick_next       = tick_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        res_pri_next    = res_pri_reg;
        res_burst_next  = res_burst_reg;
        load_we         = 1'b0;
        pri_we          = 1'b0;
        pri_waddr       = pipe_idx_reg;
        pri_wdata       = pri_rdata - 1'b1;
        rd_addr         = scan_idx_reg[AW-1:0];
        div_start       = 1'b0;
        issue           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                    res_pri_next    = '0;
                    res_burst_next  = '0;
                    tick_next       = 1'b0;
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    seen_next       = '0;
                    state_next      = S_FINISH;
                    case (func)
                        FUNC_LOAD:
                        begin
                            if (entry_reg == CW'(TABLE_DEPTH))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                load_we                       = 1'b1;
                                pri_we                        = 1'b1;
                                pri_waddr                     = entry_reg[AW-1:0];
                                pri_wdata                     = proc_priority;
                                mark_next[entry_reg[AW-1:0]]  = 1'b0;
                                entry_next                    = entry_reg + 1'b1;
                                remain_next                   = remain_reg + 1'b1;
                                res_slot_next                 = entry_wide[SLOT_W-1:0];
                            end
                        end
                        FUNC_DISPATCH:
                        begin
                            if (remain_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else if (mode_reg == MODE_RANDOM)
                            begin
                                lfsr_next  = lfsr_adv;
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_TICK:
                        begin
                            tick_next  = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    target_next = div_rem;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                issue = scan_idx_reg < entry_reg;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg && !mark_reg[pipe_idx_reg])
                begin
                    if (tick_reg)
                    begin
                        pri_we = pri_rdata != '0;
                    end
                    else if (mode_reg == MODE_RANDOM)
                    begin
                        if (cmp_eq && !found_reg)
                        begin
                            found_next = 1'b1;
                            best_next  = pipe_idx_reg;
                        end
                        seen_next = seen_reg + 1'b1;
                    end
                    else if (!found_reg || (mode_reg != MODE_FCFS && cmp_lt))
                    begin
                        found_next    = 1'b1;
                        best_next     = pipe_idx_reg;
                        best_key_next = key;
                    end
                end
                if (!issue && !pipe_vld_reg)
                begin
                    state_next = tick_reg ? S_FINISH : S_FETCH;
                end
            end
            S_FETCH:
            begin
                rd_addr             = best_reg;
                mark_next[best_reg] = 1'b1;
                state_next          = S_LATCH;
            end
            S_LATCH:
            begin
                res_slot_next  = best_wide[SLOT_W-1:0];
                res_id_next    = id_rdata;
                res_pri_next   = pri_rdata;
                res_burst_next = burst_rdata;
                remain_next    = remain_reg - 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FCFS;
            entry_reg     <= '0;
            remain_reg    <= '0;
            lfsr_reg      <= LFSR_SEED;
            mark_reg      <= '0;
            scan_idx_reg  <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            seen_reg      <= '0;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            entry_reg    <= entry_next;
            remain_reg   <= remain_next;
            lfsr_reg     <= lfsr_next;
            mark_reg     <= mark_next;
            scan_idx_reg <= scan_idx_next;
            pipe_vld_reg <= pipe_vld_next;
            found_reg    <= found_next;
            seen_reg     <= seen_next;
            tick_reg     <= tick_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        best_reg       <= best_next;
        best_key_reg   <= best_key_next;
        target_reg     <= target_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        res_pri_reg    <= res_pri_next;
        res_burst_reg  <= res_burst_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_id_reg     <= res_id_reg;
            out_pri_reg    <= res_pri_reg;
            out_burst_reg  <= res_burst_reg;
            out_left_reg   <= left_wide[LEFT_W-1:0];
        end
    end

    assign in_stall     = state_reg != S_IDLE;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot         = out_slot_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_pri_reg;
    assign out_burst    = out_burst_reg;
    assign left_count   = out_left_reg;

    a_remain_le_entry: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= entry_reg)
        else $error("more undispatched processes than loaded ones");

    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_reg <= CW'(TABLE_DEPTH))
        else $error("entry count past table depth");

    a_fetch_pick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> found_reg && !mark_reg[best_reg])
        else $error("dispatch picked no slot or a dispatched slot");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("modulo result outside random pick");

    a_remain_drop: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg < $past(remain_reg) |-> $past(state_reg) == S_LATCH)
        else $error("undispatched count fell outside a dispatch");

endmodule

`default_nettype wire
